// ===== sv/apq_pkg.sv =====
// ----------------------------------------------------------------------------
// apq_pkg
// Shared constants, codes and types for the array priority queue unit.
// ----------------------------------------------------------------------------
package apq_pkg;

  // Queue geometry.
  localparam int unsigned DEPTH     = 8;
  localparam int unsigned TAG_WIDTH = 16;

  // Widths of the external fields.
  localparam int unsigned ModeW   = 2;
  localparam int unsigned InTagW  = 16;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned StatW   = 2;
  localparam int unsigned OutCntW = 4;

  // Tags beyond the 16-bit port field can never be filled, so storage stops there.
  localparam int unsigned TagStW = (TAG_WIDTH < InTagW) ? TAG_WIDTH : InTagW;
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned IdxW   = $clog2(DEPTH);

  // Request codes.
  localparam logic [ModeW-1:0] MODE_ADD     = 2'd0;
  localparam logic [ModeW-1:0] MODE_EXTRACT = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR   = 2'd2;

  // Result status codes.
  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } apq_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request and start the scan
    logic step;    // compare one more stored entry
    logic commit;  // apply the request and load the result register
  } apq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } apq_stat_t;

endpackage

// ===== sv/apq_ctrl.sv =====
// ----------------------------------------------------------------------------
// apq_ctrl
// Sequencer for the priority queue: accepts a request, runs the maximum scan for
// an extract, then commits the request once the result register is free.
// ----------------------------------------------------------------------------
module apq_ctrl
  import apq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  apq_stat_t stat_i,
  output apq_cmd_t  cmd_o
);

  apq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  // The result register can take a new result when it is empty or drains now.
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.step = !stat_i.scan_done;
      end
      ST_COMMIT: begin
        cmd_o.commit = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SCAN))
    else $error("accepted request did not start a scan");

  a_commit_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed request produced no result");

  a_commit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

endmodule

// ===== sv/apq_dpath.sv =====
// ----------------------------------------------------------------------------
// apq_dpath
// Entry stores, fill count, maximum scan registers and result register of
// the priority queue.
// ----------------------------------------------------------------------------
module apq_dpath
  import apq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  apq_cmd_t           cmd_i,
  output apq_stat_t          stat_o,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [InTagW-1:0]  tag_i,
  input  logic [PrioW-1:0]   prio_i,
  output logic [StatW-1:0]   status_o,
  output logic [InTagW-1:0]  out_tag_o,
  output logic [PrioW-1:0]   out_prio_o,
  output logic [OutCntW-1:0] count_o,
  output logic               full_o,
  output logic               empty_o
);

  logic [TagStW-1:0] tag_store_q  [DEPTH];
  logic [PrioW-1:0]  prio_store_q [DEPTH];
  logic [CntW-1:0]   count_q, count_d;

  // Latched request.
  logic [ModeW-1:0]  req_mode_q;
  logic [TagStW-1:0] req_tag_q;
  logic [PrioW-1:0]  req_prio_q;

  // Scan state: best holds the earliest entry with the highest priority so far.
  logic [CntW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [PrioW-1:0]  best_prio_q, best_prio_d;
  logic [PrioW-1:0]  scan_prio;

  // Result register.
  logic [StatW-1:0]  res_status_q, res_status_d;
  logic [InTagW-1:0] res_tag_q, res_tag_d;
  logic [PrioW-1:0]  res_prio_q, res_prio_d;
  logic [CntW-1:0]   res_count_q;

  logic              do_add, do_extract;

  assign scan_prio = prio_store_q[idx_q[IdxW-1:0]];

  assign stat_o.scan_done = (req_mode_q != MODE_EXTRACT) || (idx_q >= count_q);

  always_comb begin
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    if (cmd_i.load) begin
      idx_d       = CntW'(1);
      best_idx_d  = '0;
      best_prio_d = prio_store_q[0];
    end else if (cmd_i.step) begin
      idx_d = CntW'(idx_q + 1'b1);
      // Strictly greater, so an earlier entry keeps a tie.
      if (scan_prio > best_prio_q) begin
        best_idx_d  = idx_q[IdxW-1:0];
        best_prio_d = scan_prio;
      end
    end
  end

  always_comb begin
    count_d      = count_q;
    res_status_d = STAT_OK;
    res_tag_d    = '0;
    res_prio_d   = '0;
    do_add       = 1'b0;
    do_extract   = 1'b0;
    case (req_mode_q)
      MODE_ADD: begin
        if (count_q == CntW'(DEPTH)) begin
          res_status_d = STAT_FULL;
        end else begin
          do_add  = 1'b1;
          count_d = CntW'(count_q + 1'b1);
        end
      end
      MODE_EXTRACT: begin
        if (count_q == '0) begin
          res_status_d = STAT_EMPTY;
        end else begin
          do_extract = 1'b1;
          res_tag_d  = InTagW'(tag_store_q[best_idx_q]);
          res_prio_d = best_prio_q;
          count_d    = CntW'(count_q - 1'b1);
        end
      end
      MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Stores: append at the tail, or close the gap behind the extracted entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_add && (count_q == CntW'(i))) begin
          tag_store_q[i]  <= req_tag_q;
          prio_store_q[i] <= req_prio_q;
        end else if (do_extract && (i < DEPTH - 1) && (IdxW'(i) >= best_idx_q) &&
                     (CntW'(i + 1) < count_q)) begin
          tag_store_q[i]  <= tag_store_q[(i + 1) % DEPTH];
          prio_store_q[i] <= prio_store_q[(i + 1) % DEPTH];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_tag_q  <= tag_i[TagStW-1:0];
      req_prio_q <= prio_i;
    end
    if (cmd_i.commit) begin
      res_status_q <= res_status_d;
      res_tag_q    <= res_tag_d;
      res_prio_q   <= res_prio_d;
      res_count_q  <= count_d;
    end
    best_prio_q <= best_prio_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      req_mode_q <= MODE_CLEAR;
      idx_q      <= CntW'(1);
      best_idx_q <= '0;
    end else begin
      if (cmd_i.commit) begin
        count_q <= count_d;
      end
      if (cmd_i.load) begin
        req_mode_q <= mode_i;
      end
      idx_q      <= idx_d;
      best_idx_q <= best_idx_d;
    end
  end

  assign status_o   = res_status_q;
  assign out_tag_o  = res_tag_q;
  assign out_prio_o = res_prio_q;
  assign count_o    = OutCntW'(res_count_q);
  assign full_o     = (res_count_q == CntW'(DEPTH));
  assign empty_o    = (res_count_q == '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above capacity");

  a_best_behind_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(best_idx_q) < idx_q)
    else $error("scan best index is not behind the scan position");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && req_mode_q == MODE_ADD && count_q < CntW'(DEPTH))
      |=> (count_q == CntW'($past(count_q) + 1'b1)))
    else $error("accepted add did not grow the queue");

endmodule

// ===== sv/array_priority_queue_extract_max_unit.sv =====
// ----------------------------------------------------------------------------
// array_priority_queue_extract_max_unit
// Bounded priority queue in arrival order with add, extract-max and clear.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                 Contents
//  s_axis    in         tdata[23:0], tuser[1:0] request: tag, priority; mode
//  m_axis    out        tdata[31:0], tuser[1:0] result: entry, count, flags;
//                                               status
//
//  Add, clear and extract on an empty or one-entry queue register their result
//  without stepping the scan; a longer extract first runs the maximum scan,
//  which reads one stored priority per cycle.
//  A new request is taken in the cycle after the result is registered.
//  Reset empties the queue; stored entries are not cleared.
//  A stalled result holds the unit in its commit step until it is taken.
// ----------------------------------------------------------------------------
module array_priority_queue_extract_max_unit
  import apq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // entry_tag[15:0], entry_priority[23:16]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_tag[15:0], out_priority[23:16],
                                      // entry_count[27:24], is_full[28],
                                      // is_empty[29], zero[31:30]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  apq_cmd_t          cmd;
  apq_stat_t         stat;
  logic [InTagW-1:0] out_tag;
  logic [PrioW-1:0]  out_prio;
  logic [OutCntW-1:0] out_count;
  logic              out_full;
  logic              out_empty;

  apq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  apq_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .mode_i     (s_axis_tuser),
    .tag_i      (s_axis_tdata[15:0]),
    .prio_i     (s_axis_tdata[23:16]),
    .status_o   (m_axis_tuser),
    .out_tag_o  (out_tag),
    .out_prio_o (out_prio),
    .count_o    (out_count),
    .full_o     (out_full),
    .empty_o    (out_empty)
  );

  assign m_axis_tdata = {2'b00, out_empty, out_full, out_count, out_prio, out_tag};

endmodule
